// File: rtl/core/quoted_printable_decoder_core_assert.svh
// Assertion macros for the quoted-printable decoder datapath.
// Expects clk and rst_n in the scope of each use.
`ifndef QUOTED_PRINTABLE_DECODER_CORE_ASSERT_SVH
`define QUOTED_PRINTABLE_DECODER_CORE_ASSERT_SVH

// cond must hold at every clock edge out of reset
`define QPD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// cons must hold in the same cycle as ante
`define QPD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/qpd_pkg.sv
// Package for the quoted-printable decoder: character constants, escape phases,
// controller states and the command/status structs. No dependencies.
package qpd_pkg;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;  // 'f'
  localparam logic [7:0] HEX_TEN  = 8'd10;

  // escape phase
  localparam logic [1:0] ESC_TEXT = 2'd0;  // plain text
  localparam logic [1:0] ESC_EQ   = 2'd1;  // after '='
  localparam logic [1:0] ESC_HIGH = 2'd2;  // high digit held

  // pending whitespace codes
  localparam logic [1:0] CODE_SP  = 2'd0;
  localparam logic [1:0] CODE_TAB = 2'd1;
  localparam logic [1:0] CODE_CR  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_OVF_EMIT,
    ST_PUSH,
    ST_FLUSH,
    ST_FLUSH_EMIT,
    ST_PLAIN,
    ST_TAIL,
    ST_EOL_HI,
    ST_EOL_NL
  } qpd_state_t;

  typedef enum logic [2:0] {
    EM_HI,      // high nibble << 4
    EM_HIHEX,   // full escape
    EM_HEX,     // low digit only
    EM_ZERO,
    EM_BYTE,    // input byte as is
    EM_CODE,    // pending whitespace from store
    EM_NL
  } qpd_emit_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    qpd_emit_t  emit_sel;
    logic       emit_flag;
    logic       emit_last;
    logic       rd_head;
    logic       rd_flush;
    logic       idx_set;
    logic       idx_two;
    logic       idx_inc;
    logic       drop1;
    logic       drop2;
    logic       push;
    logic       clr_count;
    logic       esc_wr;
    logic [1:0] esc_val;
    logic       hi_load;
    logic       pe_load;
    logic       eol_clear;
    logic       full_reset;
  } qpd_cmd_t;

  typedef struct packed {
    logic       is_lf;
    logic       is_ws;
    logic       is_eq;
    logic       passes;
    logic       last;
    logic [1:0] esc;
    logic       cnt_zero;
    logic       cnt_one;
    logic       full;
    logic       flush_done;
    logic       rd_is_cr;
    logic       pe;
    logic       lwn;
    logic       out_free;
  } qpd_status_t;

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + HEX_TEN;
    end else if (c >= CH_LA && c <= CH_LF_HEX) begin
      d = c - CH_LA + HEX_TEN;
    end
    return d[3:0];
  endfunction

  function automatic logic passes_thru(input logic [7:0] c);
    return (c == CH_TAB) || (c >= CH_SP && c <= CH_TILDE && c != CH_EQ);
  endfunction

endpackage

// File: rtl/core/qpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qpd_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/qpd_ctrl.sv
// Controller state machine of the quoted-printable decoder.
// Depends on qpd_pkg; drives datapath commands from datapath status.
module qpd_ctrl import qpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  qpd_status_t st,
  output qpd_cmd_t    cmd
);

  qpd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit_sel = EM_ZERO;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (st.is_lf) begin
          state_nxt = ST_EOL_HI;
        end else if (st.is_ws) begin
          if (st.esc == ESC_HIGH) begin
            if (st.out_free) begin
              cmd.emit     = 1'b1;
              cmd.emit_sel = EM_HI;
              cmd.esc_wr   = 1'b1;
              cmd.esc_val  = ESC_TEXT;
              state_nxt    = ST_TAIL;
            end
          end else if (st.full) begin
            if (st.esc == ESC_EQ) begin
              if (st.out_free) begin
                cmd.emit      = 1'b1;
                cmd.emit_sel  = EM_ZERO;
                cmd.emit_flag = 1'b1;
                cmd.drop2     = 1'b1;
                cmd.esc_wr    = 1'b1;
                cmd.esc_val   = ESC_TEXT;
                state_nxt     = ST_PUSH;
              end
            end else begin
              cmd.rd_head = 1'b1;
              state_nxt   = ST_OVF_EMIT;
            end
          end else begin
            state_nxt = ST_PUSH;
          end
        end else if (st.esc == ESC_HIGH) begin
          if (st.out_free) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EM_HIHEX;
            cmd.esc_wr   = 1'b1;
            cmd.esc_val  = ESC_TEXT;
            cmd.pe_load  = 1'b1;
            state_nxt    = ST_TAIL;
          end
        end else if (st.esc == ESC_EQ) begin
          if (st.cnt_zero) begin
            cmd.hi_load = 1'b1;
            cmd.esc_wr  = 1'b1;
            cmd.esc_val = ESC_HIGH;
            cmd.pe_load = 1'b1;
            state_nxt   = ST_TAIL;
          end else if (st.cnt_one) begin
            if (st.out_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_sel  = EM_HEX;
              cmd.clr_count = 1'b1;
              cmd.esc_wr    = 1'b1;
              cmd.esc_val   = ESC_TEXT;
              cmd.pe_load   = 1'b1;
              state_nxt     = ST_TAIL;
            end
          end else if (st.out_free) begin
            // escape broken by whitespace: zero byte, rest of run as text
            cmd.emit     = 1'b1;
            cmd.emit_sel = EM_ZERO;
            cmd.idx_set  = 1'b1;
            cmd.idx_two  = 1'b1;
            cmd.esc_wr   = 1'b1;
            cmd.esc_val  = ESC_TEXT;
            state_nxt    = ST_FLUSH;
          end
        end else begin
          cmd.idx_set = 1'b1;
          state_nxt   = ST_FLUSH;
        end
      end
      ST_OVF_EMIT: begin
        if (st.rd_is_cr) begin
          cmd.drop1 = 1'b1;
          state_nxt = ST_PUSH;
        end else if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EM_CODE;
          cmd.emit_flag = 1'b1;
          cmd.drop1     = 1'b1;
          state_nxt     = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = ST_TAIL;
      end
      ST_FLUSH: begin
        if (st.flush_done) begin
          cmd.clr_count = 1'b1;
          state_nxt     = ST_PLAIN;
        end else begin
          cmd.rd_flush = 1'b1;
          state_nxt    = ST_FLUSH_EMIT;
        end
      end
      ST_FLUSH_EMIT: begin
        if (st.rd_is_cr) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_FLUSH;
        end else if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_CODE;
          cmd.idx_inc  = 1'b1;
          state_nxt    = ST_FLUSH;
        end
      end
      ST_PLAIN: begin
        if (st.is_eq) begin
          cmd.pe_load = 1'b1;
          cmd.esc_wr  = 1'b1;
          cmd.esc_val = ESC_EQ;
          state_nxt   = ST_TAIL;
        end else if (st.passes) begin
          if (st.out_free) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EM_BYTE;
            cmd.pe_load  = 1'b1;
            state_nxt    = ST_TAIL;
          end
        end else begin
          cmd.pe_load = 1'b1;
          state_nxt   = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_nxt = st.last ? ST_EOL_HI : ST_IDLE;
      end
      ST_EOL_HI: begin
        if (st.esc == ESC_HIGH) begin
          if (st.out_free) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EM_HI;
            state_nxt    = ST_EOL_NL;
          end
        end else begin
          state_nxt = ST_EOL_NL;
        end
      end
      ST_EOL_NL: begin
        // hard break newline, or the closing newline of a buffer
        if (!st.pe || (st.last && !st.lwn)) begin
          if (st.out_free) begin
            cmd.emit       = 1'b1;
            cmd.emit_sel   = EM_NL;
            cmd.emit_last  = st.last;
            cmd.eol_clear  = 1'b1;
            cmd.full_reset = st.last;
            state_nxt      = ST_IDLE;
          end
        end else begin
          cmd.eol_clear  = 1'b1;
          cmd.full_reset = st.last;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/qpd_datapath.sv
// Datapath of the quoted-printable decoder: byte and escape registers,
// circular pending-whitespace store, output register. Depends on qpd_pkg, qpd_ram.
`include "quoted_printable_decoder_core_assert.svh"

module qpd_datapath import qpd_pkg::*; #(
  parameter int PENDING_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  qpd_cmd_t    cmd,
  output qpd_status_t st,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_ovf
);

  localparam int AW = $clog2(PENDING_DEPTH);
  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam logic [CW:0]   DEPTH_W = (CW+1)'(PENDING_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(PENDING_DEPTH);

  function automatic logic [AW-1:0] wrap(input logic [CW:0] s);
    logic [CW:0] r;
    r = (s >= DEPTH_W) ? (s - DEPTH_W) : s;
    return r[AW-1:0];
  endfunction

  // item and line state
  logic [7:0]    byte_r;
  logic          last_r;
  logic [1:0]    esc_r,  esc_nxt;
  logic [3:0]    hi_r,   hi_nxt;
  logic          pe_r,   pe_nxt;
  logic          lwn_r,  lwn_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r,  cnt_nxt;
  logic [CW-1:0] idx_r,  idx_nxt;

  // output register
  logic       ovalid_r, ovalid_nxt;
  logic [7:0] obyte_r;
  logic       olast_r;
  logic       oovf_r;

  logic [7:0]    emit_byte;
  logic [AW-1:0] push_addr;
  logic [AW-1:0] flush_addr;
  logic [AW-1:0] rd_addr;
  logic [1:0]    rd_code;
  logic [1:0]    ws_code;
  logic          out_free;
  logic [3:0]    b_hex;

  assign b_hex      = hex_val(byte_r);
  assign push_addr  = wrap({1'b0, CW'(head_r)} + {1'b0, cnt_r});
  assign flush_addr = wrap({1'b0, CW'(head_r)} + {1'b0, idx_r});
  assign rd_addr    = cmd.rd_head ? head_r : flush_addr;
  assign ws_code    = (byte_r == CH_SP) ? CODE_SP : ((byte_r == CH_TAB) ? CODE_TAB : CODE_CR);
  assign out_free   = !ovalid_r || out_tready;

  qpd_ram #(
    .WIDTH (2),
    .DEPTH (PENDING_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (push_addr),
    .wr_data (ws_code),
    .rd_en   (cmd.rd_head | cmd.rd_flush),
    .rd_addr (rd_addr),
    .rd_data (rd_code)
  );

  always_comb begin
    case (cmd.emit_sel)
      EM_HI:    emit_byte = {hi_r, 4'h0};
      EM_HIHEX: emit_byte = {hi_r, b_hex};
      EM_HEX:   emit_byte = {4'h0, b_hex};
      EM_ZERO:  emit_byte = 8'h00;
      EM_BYTE:  emit_byte = byte_r;
      EM_CODE:  emit_byte = (rd_code == CODE_SP) ? CH_SP : CH_TAB;
      EM_NL:    emit_byte = CH_LF;
      default:  emit_byte = 8'h00;
    endcase
  end

  always_comb begin
    esc_nxt  = esc_r;
    hi_nxt   = hi_r;
    pe_nxt   = pe_r;
    lwn_nxt  = lwn_r;
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;

    if (cmd.esc_wr)  esc_nxt = cmd.esc_val;
    if (cmd.hi_load) hi_nxt  = b_hex;
    if (cmd.pe_load) pe_nxt  = (byte_r == CH_EQ);
    if (cmd.emit)    lwn_nxt = (emit_byte == CH_LF);

    if (cmd.idx_set) idx_nxt = cmd.idx_two ? CW'(2) : '0;
    if (cmd.idx_inc) idx_nxt = idx_r + CW'(1);

    if (cmd.drop1) begin
      head_nxt = wrap({1'b0, CW'(head_r)} + (CW+1)'(1));
      cnt_nxt  = cnt_r - CW'(1);
    end
    if (cmd.drop2) begin
      head_nxt = wrap({1'b0, CW'(head_r)} + (CW+1)'(2));
      cnt_nxt  = cnt_r - CW'(2);
    end
    if (cmd.push)      cnt_nxt = cnt_r + CW'(1);
    if (cmd.clr_count) cnt_nxt = '0;

    if (cmd.eol_clear) begin
      esc_nxt = ESC_TEXT;
      hi_nxt  = 4'h0;
      pe_nxt  = 1'b0;
      cnt_nxt = '0;
    end
    if (cmd.full_reset) begin
      head_nxt = '0;
      lwn_nxt  = 1'b0;
    end

    ovalid_nxt = ovalid_r;
    if (cmd.emit) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r    <= ESC_TEXT;
      hi_r     <= 4'h0;
      pe_r     <= 1'b0;
      lwn_r    <= 1'b0;
      head_r   <= '0;
      cnt_r    <= '0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      esc_r    <= esc_nxt;
      hi_r     <= hi_nxt;
      pe_r     <= pe_nxt;
      lwn_r    <= lwn_nxt;
      head_r   <= head_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
    if (cmd.emit) begin
      obyte_r <= emit_byte;
      olast_r <= cmd.emit_last;
      oovf_r  <= cmd.emit_flag;
    end
  end

  always_comb begin
    st.is_lf      = (byte_r == CH_LF);
    st.is_ws      = (byte_r == CH_SP) || (byte_r == CH_TAB) || (byte_r == CH_CR);
    st.is_eq      = (byte_r == CH_EQ);
    st.passes     = passes_thru(byte_r);
    st.last       = last_r;
    st.esc        = esc_r;
    st.cnt_zero   = (cnt_r == '0);
    st.cnt_one    = (cnt_r == CW'(1));
    st.full       = (cnt_r == DEPTH_C);
    st.flush_done = (idx_r >= cnt_r);
    st.rd_is_cr   = (rd_code == CODE_CR);
    st.pe         = pe_r;
    st.lwn        = lwn_r;
    st.out_free   = out_free;
  end

  assign out_tvalid = ovalid_r;
  assign out_byte   = obyte_r;
  assign out_last   = olast_r;
  assign out_ovf    = oovf_r;

  `QPD_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= DEPTH_C, "pending count beyond store depth")
  `QPD_ASSERT_IMPLY(a_emit_room, cmd.emit, out_free, "result emitted over an untaken one")
  `QPD_ASSERT_IMPLY(a_flush_rd, cmd.rd_flush, idx_r < cnt_r, "flush read past pending count")
  `QPD_ASSERT_IMPLY(a_push_room, cmd.push, cnt_r < DEPTH_C, "push into full pending store")

endmodule

// File: rtl/core/quoted_printable_decoder_core.sv
// Quoted-printable decoder, top level: controller plus datapath.
// Depends on qpd_pkg, qpd_ctrl, qpd_datapath (and qpd_ram below it).
//
// Usage:
//   Input channel (in_*): one encoded byte per beat, in_tlast on the final
//   byte of a buffer. Output channel (out_*): one decoded byte per beat,
//   out_tlast on the newline that closes a buffer (none when a buffer ends
//   on a soft break after an emitted newline), out_tuser set when the byte
//   was emitted because the pending-whitespace store was full.
//   Bytes are taken one at a time: in_tready is high only while the
//   controller is idle. Each pending whitespace entry flushed takes a
//   store read in ST_FLUSH, then an emit in ST_FLUSH_EMIT (a stored CR is
//   not emitted); a buffer end adds ST_EOL_HI and ST_EOL_NL. The
//   single-port read of the pending store sets the flush cost.
//   The output is a single register: a new input beat is accepted while a
//   finished result still waits; the controller only stalls when it must
//   emit another result and the receiver holds out_tready low.
//   Reset (rst_n low, synchronous) returns to normal text, empties the
//   pending store and drops any untaken result. No clearing pass is needed.
//   Each in_tlast beat returns the decoder state to reset values afterwards.
module quoted_printable_decoder_core import qpd_pkg::*; #(
  parameter int PENDING_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // out_last
  output logic       out_tuser   // [0] pending_overflow
);

  qpd_cmd_t    cmd;
  qpd_status_t st;

  qpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  qpd_datapath #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast),
    .out_ovf    (out_tuser)
  );

endmodule
